/* hdl/gated_laplacian_stencil_defines.svh */
// ----------------------------------------------------------------------------
// gated laplacian stencil assertion macros
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GATED_LAPLACIAN_STENCIL_DEFINES_SVH
`define GATED_LAPLACIAN_STENCIL_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GLST_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GLST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GLST_ASSERT_IMPL(label, ante, cons, msg)
`define GLST_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hdl/glst_pkg.sv */
// ----------------------------------------------------------------------------
// glst_pkg
// Shared widths, codes and types of the gated laplacian stencil.
// ----------------------------------------------------------------------------
package glst_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_COLS  = 1024;
  localparam int SAMPLE_W  = 16;
  localparam int RES_W     = 19;
  localparam int CNT_W     = 21;
  localparam int REG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int DEPTH     = 2 * MAX_ROWS;
  localparam int ADDR_W    = $clog2(DEPTH);

  // input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_PAD    = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [REG_W-1:0] ROWS_RESET = REG_W'(1024);
  localparam logic [REG_W-1:0] COLS_RESET = REG_W'(1024);
  localparam logic [REG_W-1:0] ROWS_MAX   = REG_W'(MAX_ROWS);
  localparam logic [REG_W-1:0] COLS_MAX   = REG_W'(MAX_COLS);

  // window store access for one beat
  typedef struct packed {
    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic signed [SAMPLE_W-1:0] wdata;
    logic [ADDR_W-1:0]          raddr_down;
    logic [ADDR_W-1:0]          raddr_left;
  } mem_req_t;

  // per-beat control travelling alongside the store read
  typedef struct packed {
    logic                       has_res;
    logic                       inner;
    logic                       last;
    logic                       one_row;
    logic signed [SAMPLE_W-1:0] sample;
  } beat_tag_t;

  // zero reads as one, anything above the maximum saturates
  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v,
                                                 input logic [REG_W-1:0] hi);
    logic [REG_W-1:0] res;
    if (v == '0) begin
      res = REG_W'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

/* hdl/glst_in_if.sv */
// ----------------------------------------------------------------------------
// glst_in_if
// Input channel: one sample or pad beat per handshake.
// ----------------------------------------------------------------------------
interface glst_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [glst_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

/* hdl/glst_out_if.sv */
// ----------------------------------------------------------------------------
// glst_out_if
// Result channel: one laplacian value per handshake.
// ----------------------------------------------------------------------------
interface glst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [glst_pkg::RES_W-1:0] laplacian;
  logic                              last;

  modport source (output valid, output laplacian, output last, input ready);
  modport sink   (input valid, input laplacian, input last, output ready);
endinterface

/* hdl/glst_window_mem.sv */
// ----------------------------------------------------------------------------
// glst_window_mem
// Ring of recent samples: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module glst_window_mem (
  input  logic                                 clk,
  input  logic                                 re,
  input  glst_pkg::mem_req_t                   req,
  output logic signed [glst_pkg::SAMPLE_W-1:0] rd_down,
  output logic signed [glst_pkg::SAMPLE_W-1:0] rd_left
);
  import glst_pkg::*;

  logic signed [SAMPLE_W-1:0] window_r [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_down_r;
  logic signed [SAMPLE_W-1:0] rd_left_r;

  // read-before-write: at full height the left read hits the slot being
  // overwritten and must see the older sample
  always_ff @(posedge clk) begin
    if (re) begin
      rd_down_r <= window_r[req.raddr_down];
      rd_left_r <= window_r[req.raddr_left];
    end
    if (req.we) begin
      window_r[req.waddr] <= req.wdata;
    end
  end

  assign rd_down = rd_down_r;
  assign rd_left = rd_left_r;

endmodule

/* hdl/glst_ctrl.sv */
// ----------------------------------------------------------------------------
// glst_ctrl
// Configuration registers, position counter and store address generation.
// ----------------------------------------------------------------------------
`include "gated_laplacian_stencil_defines.svh"

module glst_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_fire,
  input  logic                                 in_cmd,
  input  logic signed [glst_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 cfg_we,
  input  logic [glst_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [glst_pkg::REG_W-1:0]           cfg_wdata,
  output glst_pkg::mem_req_t                   mem_req,
  output glst_pkg::beat_tag_t                  tag
);
  import glst_pkg::*;

  logic [REG_W-1:0]   rows_r, rows_nxt;
  logic [REG_W-1:0]   cols_r, cols_nxt;
  logic [CNT_W-1:0]   npix_r, npix_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [2*REG_W-1:0] prod;
  logic [CNT_W-1:0]   rows_ext;
  logic [CNT_W-1:0]   q;
  logic signed [SAMPLE_W-1:0] s;

  // configuration writes, pixel count follows the clamped sizes
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS: rows_nxt = clamp_reg(cfg_wdata, ROWS_MAX);
        REG_COLS: cols_nxt = clamp_reg(cfg_wdata, COLS_MAX);
        default:  rows_nxt = rows_r;
      endcase
    end
    prod     = rows_nxt * cols_nxt;
    npix_nxt = prod[CNT_W-1:0];
  end

  // position of the incoming beat and the pixel it completes
  always_comb begin
    rows_ext = CNT_W'(rows_r);
    q        = count_r - rows_ext;
    s        = (in_cmd == CMD_PAD) ? '0 : in_sample;

    tag.has_res = (count_r >= rows_ext) && (q < npix_r);
    tag.inner   = (q >= rows_ext) && (count_r < npix_r);
    tag.last    = tag.has_res && (q == npix_r - CNT_W'(1));
    tag.one_row = (rows_r == REG_W'(1));
    tag.sample  = s;

    mem_req.we         = in_fire;
    mem_req.waddr      = count_r[ADDR_W-1:0];
    mem_req.wdata      = s;
    mem_req.raddr_down = q[ADDR_W-1:0] + ADDR_W'(1);
    mem_req.raddr_left = q[ADDR_W-1:0] - rows_r[ADDR_W-1:0];
  end

  // counter restarts on a register write or after the final pixel
  always_comb begin
    count_nxt = count_r;
    if (cfg_we) begin
      count_nxt = '0;
    end else if (in_fire) begin
      count_nxt = tag.last ? '0 : count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ROWS_RESET;
      cols_r  <= COLS_RESET;
      npix_r  <= CNT_W'(int'(ROWS_RESET) * int'(COLS_RESET));
      count_r <= '0;
    end else begin
      rows_r  <= rows_nxt;
      cols_r  <= cols_nxt;
      npix_r  <= npix_nxt;
      count_r <= count_nxt;
    end
  end

  `GLST_ASSERT_IMPL(a_count_bound, 1'b1, count_r < npix_r + rows_ext, "position past image end")
  `GLST_ASSERT_NEXT(a_wrap_after_last, in_fire && tag.last, count_r == '0, "no restart after last")
  `GLST_ASSERT_IMPL(a_npix_match, 1'b1, npix_r == CNT_W'(rows_r) * CNT_W'(cols_r), "pixel count stale")

endmodule

/* hdl/glst_stencil.sv */
// ----------------------------------------------------------------------------
// glst_stencil
// Vertical taps, five-point sum with centre gating and the output register.
// ----------------------------------------------------------------------------
`include "gated_laplacian_stencil_defines.svh"

module glst_stencil (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_fire,
  input  glst_pkg::beat_tag_t                  tag,
  input  logic signed [glst_pkg::SAMPLE_W-1:0] rd_down,
  input  logic signed [glst_pkg::SAMPLE_W-1:0] rd_left,
  output logic                                 adv,
  glst_out_if.source                           out_ch
);
  import glst_pkg::*;

  logic                       v1_r;
  beat_tag_t                  tag1_r;
  logic signed [SAMPLE_W-1:0] cen_r, up_r;
  logic signed [SAMPLE_W-1:0] down;
  logic signed [RES_W-1:0]    sum;
  logic signed [RES_W-1:0]    lap_r, lap_nxt;
  logic                       last_r;
  logic                       out_valid_r;
  logic                       centre_pos;

  // whole pipe moves unless a result is stuck at the output
  assign adv = !out_valid_r || out_ch.ready;

  // single row: the lower neighbour is the beat itself
  always_comb begin
    down       = tag1_r.one_row ? tag1_r.sample : rd_down;
    centre_pos = !cen_r[SAMPLE_W-1] && (cen_r != '0);
    sum        = RES_W'(rd_left) + RES_W'(tag1_r.sample) + RES_W'(up_r) + RES_W'(down)
                 - (RES_W'(cen_r) <<< 2);
    lap_nxt    = (tag1_r.inner && centre_pos) ? sum : '0;
  end

  // control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_fire;
      out_valid_r <= v1_r && tag1_r.has_res;
    end
  end

  // payload: tag, tap line, result
  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r <= tag;
      if (v1_r) begin
        cen_r  <= down;
        up_r   <= cen_r;
        lap_r  <= lap_nxt;
        last_r <= tag1_r.last;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.laplacian = lap_r;
  assign out_ch.last      = last_r;

  `GLST_ASSERT_NEXT(a_no_res_no_beat, v1_r && adv && !tag1_r.has_res, !out_valid_r, "spurious beat")
  `GLST_ASSERT_NEXT(a_border_zero, v1_r && adv && !tag1_r.inner, lap_r == '0, "border not zero")
  `GLST_ASSERT_IMPL(a_last_valid, out_valid_r && last_r, !v1_r || !tag1_r.last, "double last")

endmodule

/* hdl/gated_laplacian_stencil.sv */
// Pixel q's result comes from beat q + rows via the read/tag and output registers.
// Throughput: one beat per cycle unless stalled, set by the two-read one-write store.
// The input stalls only while the output register holds an untaken beat.
// Reset (synchronous, rst_n low) sets rows and cols to 1024 and restarts the position.
// The window store is not cleared; inner results use only entries already written.
// ----------------------------------------------------------------------------
// gated_laplacian_stencil
// Streaming five-point laplacian over a column-major image with positive gating.
// ----------------------------------------------------------------------------
module gated_laplacian_stencil (
  input  logic                            clk,
  input  logic                            rst_n,
  glst_in_if.sink                         in_ch,
  glst_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [glst_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [glst_pkg::REG_W-1:0]      cfg_wdata
);
  import glst_pkg::*;

  logic                       adv;
  logic                       in_fire;
  mem_req_t                   mem_req;
  beat_tag_t                  tag;
  logic signed [SAMPLE_W-1:0] rd_down;
  logic signed [SAMPLE_W-1:0] rd_left;

  // input beat taken whenever the pipe advances
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && adv;

  glst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_cmd    (in_ch.cmd),
    .in_sample (in_ch.sample),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .mem_req   (mem_req),
    .tag       (tag)
  );

  glst_window_mem u_mem (
    .clk     (clk),
    .re      (in_fire),
    .req     (mem_req),
    .rd_down (rd_down),
    .rd_left (rd_left)
  );

  glst_stencil u_stencil (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .tag     (tag),
    .rd_down (rd_down),
    .rd_left (rd_left),
    .adv     (adv),
    .out_ch  (out_ch)
  );

endmodule
